>>> src/linear_adsr_envelope_assert.svh
// ----------------------------------------------------------------------------
// linear_adsr_envelope_assert.svh
// Assertion macros for the ADSR envelope block. Clocked on clk, disabled
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ADSR_ENVELOPE_ASSERT_SVH
`define LINEAR_ADSR_ENVELOPE_ASSERT_SVH

// same-cycle implication
`define LADSR_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define LADSR_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> src/ladsr_pkg.sv
// ----------------------------------------------------------------------------
// ladsr_pkg
// Types and fixed codes for the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ladsr_pkg;

  // config space: five 32-bit registers at 4-byte stride
  localparam int CFG_ADDR_W = 5;

  localparam logic [2:0] REG_ATTACK      = 3'd0;
  localparam logic [2:0] REG_DECAY       = 3'd1;
  localparam logic [2:0] REG_SUSTAIN     = 3'd2;
  localparam logic [2:0] REG_SUSTAIN_MAX = 3'd3;
  localparam logic [2:0] REG_RELEASE     = 3'd4;

  localparam logic [1:0] PH_ATTACK  = 2'd0;
  localparam logic [1:0] PH_DECAY   = 2'd1;
  localparam logic [1:0] PH_SUSTAIN = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEL,
    ST_MUL,
    ST_DIV,
    ST_WB
  } st_t;

  // how the final level is formed from the quotient
  typedef enum logic [2:0] {
    LS_QUOT,
    LS_FULL_SUB,
    LS_SUS_SUB,
    LS_HELD,
    LS_ZERO
  } lvl_sel_t;

endpackage

`default_nettype wire

>>> src/linear_adsr_envelope.sv
// ----------------------------------------------------------------------------
// linear_adsr_envelope
// Linear ADSR envelope generator. Each input beat carries the gate bit of one
// audio sample and yields one output beat with the level (unsigned, all ones
// is full scale) and the phase. A ramp sample passes through the states EVAL,
// SEL, MUL, DIV and WB before the next input beat; a sustain sample or a
// release sample past its span skips DIV. The ramp time is set by the shared
// restoring divider, which retires one quotient bit per cycle after the
// multiply registered in MUL. The result sits in an output register, so a
// new sample is taken while the last one waits. Registers (APB, 4-byte
// stride): attack, decay, sustain level, sustain max, release; write them
// only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_adsr_envelope #(
  parameter int DURATION_BITS = 20,
  parameter int LEVEL_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_gate,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [LEVEL_BITS-1:0]           out_level,
  output logic [1:0]                      out_phase,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ladsr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import ladsr_pkg::*;

  localparam int CNT_W  = DURATION_BITS + 3;
  localparam int PROD_W = LEVEL_BITS + DURATION_BITS;
  localparam int STEP_W = $clog2(LEVEL_BITS);
  localparam logic [LEVEL_BITS-1:0] FULL = {LEVEL_BITS{1'b1}};

  // ---------------- config registers ----------------
  logic [DURATION_BITS-1:0] attack_r;
  logic [DURATION_BITS-1:0] decay_r;
  logic [LEVEL_BITS-1:0]    sustain_r;
  logic [DURATION_BITS-1:0] sus_max_r;
  logic [DURATION_BITS-1:0] release_r;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= DURATION_BITS'(441);
      decay_r   <= DURATION_BITS'(1544);
      sustain_r <= LEVEL_BITS'(32768);
      sus_max_r <= DURATION_BITS'(22050);
      release_r <= DURATION_BITS'(16405);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ATTACK:      attack_r  <= pwdata[DURATION_BITS-1:0];
        REG_DECAY:       decay_r   <= pwdata[DURATION_BITS-1:0];
        REG_SUSTAIN:     sustain_r <= pwdata[LEVEL_BITS-1:0];
        REG_SUSTAIN_MAX: sus_max_r <= pwdata[DURATION_BITS-1:0];
        REG_RELEASE:     release_r <= pwdata[DURATION_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ATTACK:      prdata = 32'(attack_r);
      REG_DECAY:       prdata = 32'(decay_r);
      REG_SUSTAIN:     prdata = 32'(sustain_r);
      REG_SUSTAIN_MAX: prdata = 32'(sus_max_r);
      REG_RELEASE:     prdata = 32'(release_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  st_t state_r, state_nxt;
  logic wb_go;

  logic                     gate_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         drop_r;
  logic [LEVEL_BITS-1:0]    held_r;

  logic                     lt_a_r;
  logic [CNT_W-1:0]         ad_r;
  logic [CNT_W-1:0]         ediff_r;
  logic [DURATION_BITS-1:0] tda_r;
  logic [CNT_W-1:0]         rs_r;
  lvl_sel_t                 sel_r;
  logic [1:0]               phase_r;
  logic                     use_div_r;
  logic [LEVEL_BITS-1:0]    mul_a_r;
  logic [DURATION_BITS-1:0] mul_b_r;
  logic [DURATION_BITS-1:0] div_r;
  logic [DURATION_BITS-1:0] rem_r;
  logic [LEVEL_BITS-1:0]    low_r;
  logic [LEVEL_BITS-1:0]    quot_r;
  logic [STEP_W-1:0]        step_r;
  logic                     wrap_r;

  logic                     out_valid_r;
  logic [LEVEL_BITS-1:0]    out_level_r;
  logic [1:0]               out_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    wb_go     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: state_nxt = ST_SEL;
      ST_SEL:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = use_div_r ? ST_DIV : ST_WB;
      ST_DIV: begin
        if (step_r == '0) state_nxt = ST_WB;
      end
      ST_WB: begin
        // output register free or draining this cycle
        if (!out_valid_r || out_ready) begin
          wb_go     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- evaluate: compares and differences ----------------
  logic [CNT_W-1:0] ad_sum;
  logic [CNT_W-1:0] t_minus_a;
  logic [CNT_W-1:0] ediff;

  assign ad_sum    = CNT_W'(attack_r) + CNT_W'(decay_r);
  assign t_minus_a = cnt_r - CNT_W'(attack_r);
  // count below drop count counts as no elapsed release time
  assign ediff     = (cnt_r >= drop_r) ? (cnt_r - drop_r) : '0;

  // ---------------- select: pick phase and divider operands ----------------
  logic                     sel_lt_ad;
  logic                     sel_rel_zero;
  lvl_sel_t                 sel_kind;
  logic [1:0]               sel_phase;
  logic                     sel_use_div;
  logic [LEVEL_BITS-1:0]    sel_mul_a;
  logic [DURATION_BITS-1:0] sel_mul_b;
  logic [DURATION_BITS-1:0] sel_div;

  assign sel_lt_ad    = cnt_r < ad_r;
  assign sel_rel_zero = (release_r == '0) || (ediff_r >= CNT_W'(release_r));

  always_comb begin
    sel_kind    = LS_ZERO;
    sel_phase   = PH_RELEASE;
    sel_use_div = 1'b0;
    sel_mul_a   = FULL;
    sel_mul_b   = cnt_r[DURATION_BITS-1:0];
    sel_div     = attack_r;
    if (gate_r) begin
      if (lt_a_r) begin
        sel_kind    = LS_QUOT;
        sel_phase   = PH_ATTACK;
        sel_use_div = 1'b1;
      end else if (sel_lt_ad) begin
        sel_kind    = LS_FULL_SUB;
        sel_phase   = PH_DECAY;
        sel_use_div = 1'b1;
        sel_mul_a   = FULL - sustain_r;
        sel_mul_b   = tda_r;
        sel_div     = decay_r;
      end else begin
        sel_kind  = LS_HELD;
        sel_phase = PH_SUSTAIN;
      end
    end else if (!sel_rel_zero) begin
      sel_kind    = LS_SUS_SUB;
      sel_use_div = 1'b1;
      sel_mul_a   = sustain_r;
      sel_mul_b   = ediff_r[DURATION_BITS-1:0];
      sel_div     = release_r;
    end
  end

  // ---------------- shared multiply and restoring divide ----------------
  logic [PROD_W-1:0]        prod;
  logic [DURATION_BITS:0]   trial;
  logic                     trial_ge;
  logic [DURATION_BITS:0]   trial_diff;
  logic [LEVEL_BITS-1:0]    level_calc;

  assign prod       = PROD_W'(mul_a_r) * PROD_W'(mul_b_r);
  assign trial      = {rem_r, low_r[LEVEL_BITS-1]};
  assign trial_ge   = trial >= {1'b0, div_r};
  assign trial_diff = trial - {1'b0, div_r};

  always_comb begin
    case (sel_r)
      LS_QUOT:     level_calc = quot_r;
      LS_FULL_SUB: level_calc = FULL - quot_r;
      LS_SUS_SUB:  level_calc = sustain_r - quot_r;
      LS_HELD:     level_calc = held_r;
      default:     level_calc = '0;
    endcase
  end

  // payload / datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) gate_r <= in_gate;
      end
      ST_EVAL: begin
        lt_a_r  <= cnt_r < CNT_W'(attack_r);
        ad_r    <= ad_sum;
        ediff_r <= ediff;
        tda_r   <= t_minus_a[DURATION_BITS-1:0];
      end
      ST_SEL: begin
        rs_r      <= CNT_W'(sus_max_r) + CNT_W'(release_r);
        sel_r     <= sel_kind;
        phase_r   <= sel_phase;
        use_div_r <= sel_use_div;
        mul_a_r   <= sel_mul_a;
        mul_b_r   <= sel_mul_b;
        div_r     <= sel_div;
      end
      ST_MUL: begin
        // product high part is already below the divisor
        rem_r  <= prod[PROD_W-1:LEVEL_BITS];
        low_r  <= prod[LEVEL_BITS-1:0];
        quot_r <= '0;
        step_r <= STEP_W'(LEVEL_BITS - 1);
        wrap_r <= cnt_r > (ad_r + rs_r);
      end
      ST_DIV: begin
        rem_r  <= trial_ge ? trial_diff[DURATION_BITS-1:0] : trial[DURATION_BITS-1:0];
        low_r  <= {low_r[LEVEL_BITS-2:0], 1'b0};
        quot_r <= {quot_r[LEVEL_BITS-2:0], trial_ge};
        step_r <= step_r - 1'b1;
      end
      default: ;
    endcase
    if (wb_go) begin
      out_level_r <= level_calc;
      out_phase_r <= phase_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      drop_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wb_go) begin
        held_r      <= level_calc;
        out_valid_r <= 1'b1;
        if (wrap_r) begin
          cnt_r  <= '0;
          drop_r <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
          if (gate_r) drop_r <= cnt_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

  // ---------------- assertions ----------------
`include "linear_adsr_envelope_assert.svh"

  `LADSR_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_r == ST_EVAL, "beat not started")
  `LADSR_ASSERT_IMP(a_rem_below_div, state_r == ST_DIV, rem_r < div_r, "divider remainder overflow")
  `LADSR_ASSERT_IMP(a_rel_quot, state_r == ST_WB && sel_r == LS_SUS_SUB, quot_r <= sustain_r, "release quotient too large")
  `LADSR_ASSERT_NXT(a_wrap_clears, wb_go && wrap_r, cnt_r == '0 && drop_r == '0, "counter wrap missed")

endmodule

`default_nettype wire

>>> tb/linear_adsr_envelope_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_adsr_envelope_tb
// Self-checking bench for the ADSR envelope block. Gate beats go in and each
// returned level/phase beat is checked against a local envelope predictor.
// Covers register extremes, register masking, and random note sequences
// under three input/output stall mixes.
// ----------------------------------------------------------------------------
module linear_adsr_envelope_tb;
  import ladsr_pkg::*;

  localparam int DUR_W     = 20;
  localparam int LVL_W     = 16;
  localparam int CNT_W     = DUR_W + 3;
  localparam int STALL_MAX = 4000;
  localparam logic [63:0] FULL_SCALE = 64'hFFFF;
  localparam logic [63:0] DUR_MASK   = 64'hFFFFF;
  localparam logic [2:0]  REG_UNMAPPED = 3'd5;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [1:0]       phase;
  } env_sample_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_gate = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [LVL_W-1:0]      out_level;
  logic [1:0]            out_phase;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  linear_adsr_envelope #(
    .DURATION_BITS(DUR_W),
    .LEVEL_BITS   (LVL_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_gate  (in_gate),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_level(out_level),
    .out_phase(out_phase),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state and register copy
  logic [63:0]      attack_len   = 64'd441;
  logic [63:0]      decay_len    = 64'd1544;
  logic [63:0]      sustain_lvl  = 64'd32768;
  logic [63:0]      sustain_span = 64'd22050;
  logic [63:0]      release_len  = 64'd16405;
  logic [CNT_W-1:0] sample_ctr   = '0;
  logic [CNT_W-1:0] drop_ctr     = '0;
  logic [LVL_W-1:0] last_level   = '0;

  env_sample_t pending_samples[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int samples_sent = 0;
  int samples_checked = 0;
  int reg_writes = 0;
  int idle_cycles = 0;

  function automatic env_sample_t next_envelope_sample(input logic gate);
    env_sample_t smp;
    logic [63:0] t;
    logic [63:0] elapsed;
    logic [63:0] lvl;
    logic [1:0]  ph;
    t = 64'(sample_ctr);
    if (gate) begin
      drop_ctr = sample_ctr;
      if (t < attack_len) begin
        lvl = (t * FULL_SCALE) / attack_len;
        ph  = PH_ATTACK;
      end else if (t < attack_len + decay_len) begin
        lvl = FULL_SCALE - ((FULL_SCALE - sustain_lvl) * (t - attack_len)) / decay_len;
        ph  = PH_DECAY;
      end else begin
        lvl = 64'(last_level);
        ph  = PH_SUSTAIN;
      end
    end else begin
      elapsed = (t >= 64'(drop_ctr)) ? t - 64'(drop_ctr) : 64'd0;
      ph = PH_RELEASE;
      if (release_len == 0 || elapsed >= release_len) begin
        lvl = 64'd0;
      end else begin
        lvl = sustain_lvl - (sustain_lvl * elapsed) / release_len;
      end
    end
    last_level = lvl[LVL_W-1:0];
    sample_ctr = sample_ctr + 1'b1;
    // wrap once the count passes the summed spans
    if (t > attack_len + decay_len + sustain_span + release_len) begin
      sample_ctr = '0;
      drop_ctr   = '0;
    end
    smp.level = lvl[LVL_W-1:0];
    smp.phase = ph;
    return smp;
  endfunction

  function automatic void apply_register(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      REG_ATTACK:      attack_len   = 64'(value) & DUR_MASK;
      REG_DECAY:       decay_len    = 64'(value) & DUR_MASK;
      REG_SUSTAIN:     sustain_lvl  = 64'(value) & FULL_SCALE;
      REG_SUSTAIN_MAX: sustain_span = 64'(value) & DUR_MASK;
      REG_RELEASE:     release_len  = 64'(value) & DUR_MASK;
      default: ;
    endcase
  endfunction

  // result side: random back-pressure, check every beat
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    env_sample_t exp_smp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected beat: level %0d phase %0d", out_level, out_phase);
        mismatch_count++;
      end else begin
        exp_smp = pending_samples.pop_front();
        samples_checked++;
        if (out_level !== exp_smp.level) begin
          $error("level mismatch: expected %0d, got %0d", exp_smp.level, out_level);
          mismatch_count++;
        end
        if (out_phase !== exp_smp.phase) begin
          $error("phase mismatch: expected %0d, got %0d", exp_smp.phase, out_phase);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_MAX) begin
      $display("timeout: no beat for %0d cycles, %0d results pending",
               STALL_MAX, pending_samples.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic gate);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_gate  <= gate;
    do @(posedge clk); while (!in_ready);
    pending_samples.push_back(next_envelope_sample(gate));
    samples_sent++;
  endtask

  task automatic send_note(input int held, input int released);
    repeat (held) send_sample(1'b1);
    repeat (released) send_sample(1'b0);
  endtask

  // stop sending and let every pending beat come back
  task automatic drain_envelope();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(idx, value);
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_envelope(input logic [31:0] a, input logic [31:0] d,
                              input logic [31:0] s, input logic [31:0] m,
                              input logic [31:0] r);
    drain_envelope();
    write_register(REG_ATTACK, a);
    write_register(REG_DECAY, d);
    write_register(REG_SUSTAIN, s);
    write_register(REG_SUSTAIN_MAX, m);
    write_register(REG_RELEASE, r);
  endtask

  task automatic test_reset_defaults();
    send_note(4, 2);
  endtask

  // attack of one sample, no decay, no release, wrap right after
  task automatic test_short_spans();
    set_envelope(32'd1, 32'd0, 32'hFFFF, 32'd0, 32'd0);
    send_note(3, 2);
  endtask

  task automatic test_long_spans();
    set_envelope(32'hFFFFF, 32'hFFFFF, 32'd0, 32'hFFFFF, 32'hFFFFF);
    send_note(2, 2);
  endtask

  // junk above the register widths, a write to an unmapped slot,
  // release running past its span, then sustain holding the release level
  task automatic test_register_masking();
    set_envelope(32'hABC0_0002, 32'hFFF0_0002, 32'hDEAD_4000, 32'h8000_0003,
                 32'h7FF0_0004);
    write_register(REG_UNMAPPED, 32'h0000_0001);
    send_note(7, 5);
    send_note(2, 0);
  endtask

  task automatic test_random_envelopes(input int n_items);
    int target;
    logic [31:0] a, d, s, m, r;
    target = samples_sent + n_items;
    while (samples_sent < target) begin
      a = $urandom_range(1, 24);
      d = $urandom_range(0, 24);
      s = $urandom_range(0, 16'hFFFF);
      m = $urandom_range(0, 30);
      r = $urandom_range(0, 40);
      case ($urandom_range(0, 11))
        0: a = $urandom_range(1, 20'hFFFFF);
        1: d = $urandom_range(0, 20'hFFFFF);
        2: s = 32'd0;
        3: s = 32'hFFFF;
        4: r = $urandom_range(0, 20'hFFFFF);
        5: r = 32'd0;
        6: d = 32'd0;
        7: m = $urandom_range(0, 20'hFFFFF);
        default: ;
      endcase
      set_envelope(a, d, s, m, r);
      repeat ($urandom_range(2, 4)) begin
        if (samples_sent < target) begin
          if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) send_sample($urandom_range(0, 1));
          end else begin
            send_note($urandom_range(1, 60), $urandom_range(0, 60));
          end
          if ($urandom_range(7) == 0) drain_envelope();
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 7;
    recv_idle_pct = 64;
    test_reset_defaults();
    test_short_spans();
    test_long_spans();
    test_register_masking();
    test_random_envelopes(480);

    send_idle_pct = 64;
    recv_idle_pct = 7;
    test_random_envelopes(480);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_envelopes(480);

    drain_envelope();
    repeat (40) @(posedge clk);

    $display("Sent %0d gate samples, checked %0d envelope beats, %0d register writes",
             samples_sent, samples_checked, reg_writes);
    $display("Stall mixes: input-light/output-heavy, input-heavy/output-light, none");
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
